// File: hdl/cpg_pkg.sv
// shared types and constants for the circle point generator
// no dependencies; imported by every module of the block
package cpg_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int SURF_BITS          = 12;
   localparam int DEC_BITS           = 16;
   localparam int CSR_IDX_BITS       = 2;

   localparam logic [SURF_BITS-1:0] SURF_WIDTH_RESET  = 12'd640;
   localparam logic [SURF_BITS-1:0] SURF_HEIGHT_RESET = 12'd480;

   typedef enum logic [0:0] {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FILL_MODE   = 2'd0,
      CSR_SURF_WIDTH  = 2'd1,
      CSR_SURF_HEIGHT = 2'd2
   } csr_idx_type;

   // handoff from the walk stage to the burst register
   typedef struct packed {
      logic load;
      logic fill;
      logic done;
   } burst_ctrl_type;

endpackage

// File: hdl/cpg_walk.sv
// circle walk state, symmetric point calculation, clamping and error update
// depends on cpg_pkg
module cpg_walk #(
   parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic                               command,
   input  logic signed [COORD_BITS-1:0]       center_x,
   input  logic signed [COORD_BITS-1:0]       center_y,
   input  logic [COORD_BITS-2:0]              radius,
   input  logic [31:0]                        pixel_color,
   input  logic                               fill_mode,
   input  logic [cpg_pkg::SURF_BITS-1:0]      surface_width,
   input  logic [cpg_pkg::SURF_BITS-1:0]      surface_height,
   output cpg_pkg::burst_ctrl_type            ctrl,
   output logic [COORD_BITS:0]                x_right,
   output logic [COORD_BITS:0]                x_left,
   output logic [COORD_BITS:0]                y_lower,
   output logic [COORD_BITS:0]                y_upper,
   output logic [31:0]                        color
);
   import cpg_pkg::*;

   localparam int OUT_W  = COORD_BITS + 1;
   localparam int CALC_W = ((COORD_BITS > SURF_BITS) ? COORD_BITS : SURF_BITS) + 2;
   localparam int SUM_W  = ((DEC_BITS > OUT_W) ? DEC_BITS : OUT_W) + 1;

   logic [COORD_BITS-1:0]        off_x_ff, off_x_in;
   logic signed [OUT_W-1:0]      off_y_ff, off_y_in;
   logic signed [DEC_BITS-1:0]   dec_ff, dec_in;
   logic signed [COORD_BITS-1:0] cx_ff, cx_in;
   logic signed [COORD_BITS-1:0] cy_ff, cy_in;
   logic [31:0]                  color_ff, color_in;

   logic signed [CALC_W-1:0] cx_w, cy_w, x_w, y_w;
   logic signed [CALC_W-1:0] xp_raw, xm_raw, yp_raw, ym_raw;
   logic signed [CALC_W-1:0] x_lim, y_lim;
   logic signed [CALC_W-1:0] xp_cl, xm_cl, yp_cl, ym_cl;

   logic signed [SUM_W-1:0]    dy_sum;
   logic                       walk_done, d_neg, d_pos, s_pos, is_step;
   logic [COORD_BITS:0]        x_inc;
   logic signed [OUT_W-1:0]    y_dec;
   logic [DEC_BITS-1:0]        xi_d, yd_d;
   logic signed [DEC_BITS-1:0] dec_a, dec_b, dec_c, dec_start;

   // point offsets around the held center
   assign cx_w = {{(CALC_W-COORD_BITS){cx_ff[COORD_BITS-1]}}, cx_ff};
   assign cy_w = {{(CALC_W-COORD_BITS){cy_ff[COORD_BITS-1]}}, cy_ff};
   assign x_w  = {{(CALC_W-COORD_BITS){1'b0}}, off_x_ff};
   assign y_w  = {{(CALC_W-OUT_W){off_y_ff[OUT_W-1]}}, off_y_ff};

   assign xp_raw = cx_w + x_w;
   assign xm_raw = cx_w - x_w;
   assign yp_raw = cy_w + y_w;
   assign ym_raw = cy_w - y_w;

   assign x_lim = {{(CALC_W-SURF_BITS){1'b0}}, surface_width}  - CALC_W'(1);
   assign y_lim = {{(CALC_W-SURF_BITS){1'b0}}, surface_height} - CALC_W'(1);

   // upper edges clamp to size minus one, left edge to -1, top edge to 0
   assign xp_cl = (xp_raw > x_lim) ? x_lim : xp_raw;
   assign yp_cl = (yp_raw > y_lim) ? y_lim : yp_raw;
   assign xm_cl = xm_raw[CALC_W-1] ? {CALC_W{1'b1}} : xm_raw;
   assign ym_cl = ym_raw[CALC_W-1] ? {CALC_W{1'b0}} : ym_raw;

   // error walk decision
   assign walk_done = off_y_ff[OUT_W-1];
   assign dy_sum    = {{(SUM_W-DEC_BITS){dec_ff[DEC_BITS-1]}}, dec_ff}
                    + {{(SUM_W-OUT_W){off_y_ff[OUT_W-1]}}, off_y_ff};
   assign d_neg     = dec_ff[DEC_BITS-1];
   assign d_pos     = !dec_ff[DEC_BITS-1] && (dec_ff != '0);
   assign s_pos     = !dy_sum[SUM_W-1] && (dy_sum != '0);

   assign x_inc = {1'b0, off_x_ff} + (COORD_BITS+1)'(1);
   assign y_dec = off_y_ff - OUT_W'(1);
   assign xi_d  = DEC_BITS'(x_inc);
   assign yd_d  = DEC_BITS'(y_dec);

   // decision arithmetic wraps at its register width
   assign dec_a = dec_ff + {xi_d[DEC_BITS-2:0], 1'b0} + DEC_BITS'(1);
   assign dec_b = dec_ff - {yd_d[DEC_BITS-2:0], 1'b0} - DEC_BITS'(1);
   assign dec_c = dec_ff + {xi_d[DEC_BITS-2:0], 1'b0} - {yd_d[DEC_BITS-2:0], 1'b0};
   assign dec_start = DEC_BITS'(1) - DEC_BITS'({radius, 1'b0});

   assign is_step = (command == CMD_STEP);

   always_comb begin
      off_x_in = off_x_ff;
      off_y_in = off_y_ff;
      dec_in   = dec_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      color_in = color_ff;
      if (accept) begin
         if (!is_step) begin
            off_x_in = '0;
            off_y_in = OUT_W'(radius);
            dec_in   = dec_start;
            cx_in    = center_x;
            cy_in    = center_y;
            color_in = pixel_color;
         end else if (!walk_done) begin
            priority if (d_neg && !s_pos) begin
               off_x_in = x_inc[COORD_BITS-1:0];
               dec_in   = dec_a;
            end else if (d_pos && s_pos) begin
               off_y_in = y_dec;
               dec_in   = dec_b;
            end else begin
               off_x_in = x_inc[COORD_BITS-1:0];
               off_y_in = y_dec;
               dec_in   = dec_c;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_x_ff <= '0;
         off_y_ff <= '1;
         dec_ff   <= '0;
         cx_ff    <= '0;
         cy_ff    <= '0;
         color_ff <= '0;
      end else begin
         off_x_ff <= off_x_in;
         off_y_ff <= off_y_in;
         dec_ff   <= dec_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         color_ff <= color_in;
      end
   end

   assign ctrl.load = accept && is_step;
   assign ctrl.fill = fill_mode;
   assign ctrl.done = walk_done;
   assign x_right   = xp_cl[OUT_W-1:0];
   assign x_left    = xm_cl[OUT_W-1:0];
   assign y_lower   = yp_cl[OUT_W-1:0];
   assign y_upper   = ym_cl[OUT_W-1:0];
   assign color     = color_ff;

endmodule

// File: hdl/cpg_burst.sv
// result register holding one step's points, sent one word per cycle while rsp_ready is high
// depends on cpg_pkg
module cpg_burst #(
   parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cpg_pkg::burst_ctrl_type       ctrl,
   input  logic [COORD_BITS:0]           x_right,
   input  logic [COORD_BITS:0]           x_left,
   input  logic [COORD_BITS:0]           y_lower,
   input  logic [COORD_BITS:0]           y_upper,
   input  logic [31:0]                   color,
   output logic                          slot_free,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_BITS:0]    rsp_x_start,
   output logic signed [COORD_BITS:0]    rsp_x_end,
   output logic signed [COORD_BITS:0]    rsp_row,
   output logic [31:0]                   rsp_color_out,
   output logic                          rsp_done_res,
   output logic                          rsp_last
);
   import cpg_pkg::*;

   localparam int OUT_W = COORD_BITS + 1;

   logic             valid_ff, valid_in;
   logic [1:0]       beat_ff, beat_in;
   logic             fill_ff, done_ff;
   logic [OUT_W-1:0] xr_ff, xl_ff, yl_ff, yu_ff;
   logic [31:0]      color_ff;
   logic             take, last_beat;
   logic [OUT_W-1:0] col_sel, row_sel;

   // done: single word; fill: two spans; outline: four points
   assign last_beat = done_ff || (fill_ff ? (beat_ff == 2'd1) : (beat_ff == 2'd3));
   assign take      = valid_ff && rsp_ready;
   assign slot_free = !valid_ff || (rsp_ready && last_beat);

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (take) begin
         beat_in = beat_ff + 2'd1;
         if (last_beat) begin
            valid_in = 1'b0;
         end
      end
      if (ctrl.load) begin
         valid_in = 1'b1;
         beat_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         fill_ff  <= ctrl.fill;
         done_ff  <= ctrl.done;
         xr_ff    <= x_right;
         xl_ff    <= x_left;
         yl_ff    <= y_lower;
         yu_ff    <= y_upper;
         color_ff <= color;
      end
   end

   assign col_sel = beat_ff[1] ? xl_ff : xr_ff;
   assign row_sel = beat_ff[0] ? yu_ff : yl_ff;

   assign rsp_valid     = valid_ff;
   assign rsp_x_start   = done_ff ? '0 : (fill_ff ? xr_ff : col_sel);
   assign rsp_x_end     = done_ff ? '0 : (fill_ff ? xl_ff : col_sel);
   assign rsp_row       = done_ff ? '0 : row_sel;
   assign rsp_color_out = color_ff;
   assign rsp_done_res  = done_ff;
   assign rsp_last      = last_beat;

   a_done_single : assert property (@(posedge clock) disable iff (reset)
      (valid_ff && done_ff) |-> (rsp_last && beat_ff == 2'd0 && rsp_row == '0))
      else $error("done word is not a lone last word");

   a_outline_point : assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !fill_ff && !done_ff) |-> (rsp_x_start == rsp_x_end))
      else $error("outline point with distinct span ends");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (ctrl.load && valid_ff) |-> (rsp_ready && rsp_last))
      else $error("new step loaded over undelivered words");

   a_burst_continues : assert property (@(posedge clock) disable iff (reset)
      (take && !last_beat) |=> (valid_ff && beat_ff == $past(beat_ff) + 2'd1))
      else $error("burst dropped before its last word");

endmodule

// File: hdl/circle_point_generator_core.sv
// top level of the circle point generator: config registers, walk and burst
// depends on cpg_pkg, cpg_walk, cpg_burst
//
// Midpoint circle rasterizer. A start word (command 0) loads center, radius and
// color and is taken with no result. Each step word (command 1)
// yields the symmetric points of the current offset and advances the error walk:
// four single points in outline mode, two horizontal spans in fill mode, or one
// done word once the walk has finished (also for a step right after reset).
// Step arithmetic and clamping run in the same cycle the word is taken; the
// points are parked in a result register and leave one word per cycle while
// rsp_ready is high; further requests wait until the final word of a step. The
// next request can be taken in the cycle the final word of a step is taken.
// Configuration writes are taken at any time, but are meant for idle periods.
module circle_point_generator_core #(
   parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_command,
   input  logic signed [COORD_BITS-1:0]       req_center_x,
   input  logic signed [COORD_BITS-1:0]       req_center_y,
   input  logic [COORD_BITS-2:0]              req_radius,
   input  logic [31:0]                        req_pixel_color,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [COORD_BITS:0]         rsp_x_start,
   output logic signed [COORD_BITS:0]         rsp_x_end,
   output logic signed [COORD_BITS:0]         rsp_row,
   output logic [31:0]                        rsp_color_out,
   output logic                               rsp_done_res,
   output logic                               rsp_last,
   // register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cpg_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [cpg_pkg::SURF_BITS-1:0]      csr_data
);
   import cpg_pkg::*;

   logic                 fill_mode_ff, fill_mode_in;
   logic [SURF_BITS-1:0] surf_w_ff, surf_w_in;
   logic [SURF_BITS-1:0] surf_h_ff, surf_h_in;

   logic                 req_take;
   logic                 slot_free;
   burst_ctrl_type       burst_ctrl;
   logic [COORD_BITS:0]  x_right, x_left, y_lower, y_upper;
   logic [31:0]          walk_color;

   // config registers, always writable
   assign csr_ready = 1'b1;

   always_comb begin
      fill_mode_in = fill_mode_ff;
      surf_w_in    = surf_w_ff;
      surf_h_in    = surf_h_ff;
      if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_FILL_MODE:   fill_mode_in = csr_data[0];
            CSR_SURF_WIDTH:  surf_w_in    = csr_data;
            CSR_SURF_HEIGHT: surf_h_in    = csr_data;
            default:         ; // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_mode_ff <= 1'b0;
         surf_w_ff    <= SURF_WIDTH_RESET;
         surf_h_ff    <= SURF_HEIGHT_RESET;
      end else begin
         fill_mode_ff <= fill_mode_in;
         surf_w_ff    <= surf_w_in;
         surf_h_ff    <= surf_h_in;
      end
   end

   // a request is taken whenever the result register is empty or emptying
   assign req_ready = slot_free;
   assign req_take  = req_valid && slot_free;

   cpg_walk #(
      .COORD_BITS (COORD_BITS)
   ) u_walk (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_take),
      .command        (req_command),
      .center_x       (req_center_x),
      .center_y       (req_center_y),
      .radius         (req_radius),
      .pixel_color    (req_pixel_color),
      .fill_mode      (fill_mode_ff),
      .surface_width  (surf_w_ff),
      .surface_height (surf_h_ff),
      .ctrl           (burst_ctrl),
      .x_right        (x_right),
      .x_left         (x_left),
      .y_lower        (y_lower),
      .y_upper        (y_upper),
      .color          (walk_color)
   );

   // points of one step, delivered in order with last on the final word
   cpg_burst #(
      .COORD_BITS (COORD_BITS)
   ) u_burst (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (burst_ctrl),
      .x_right       (x_right),
      .x_left        (x_left),
      .y_lower       (y_lower),
      .y_upper       (y_upper),
      .color         (walk_color),
      .slot_free     (slot_free),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_x_start   (rsp_x_start),
      .rsp_x_end     (rsp_x_end),
      .rsp_row       (rsp_row),
      .rsp_color_out (rsp_color_out),
      .rsp_done_res  (rsp_done_res),
      .rsp_last      (rsp_last)
   );

endmodule

// File: tb/sv/testbench.sv
// self-checking bench for circle_point_generator_core: directed table, then random walks
// depends on cpg_pkg and the circle_point_generator_core rtl with its cpg_walk and cpg_burst
module testbench;
   import cpg_pkg::*;

   // one result word as it leaves the block
   typedef struct packed {
      logic signed [12:0] x_start;
      logic signed [12:0] x_end;
      logic signed [12:0] row;
      logic [31:0]        color;
      logic               done;
      logic               last;
   } raster_word_type;

   // one request word, plus an optional hand-typed first result
   typedef struct packed {
      cmd_type            command;
      logic signed [11:0] center_x;
      logic signed [11:0] center_y;
      logic [10:0]        radius;
      logic [31:0]        pixel_color;
      logic               pinned;
      raster_word_type    pin;
   } stim_row_type;

   localparam raster_word_type NO_PIN = '0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNMAPPED = 2'd3;
   localparam int N_DIRECTED = 25;
   localparam int N_PHASES = 7;
   localparam int PHASE_ITEMS = 27;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_command = 1'b0;
   logic signed [11:0] req_center_x = '0;
   logic signed [11:0] req_center_y = '0;
   logic [10:0]        req_radius = '0;
   logic [31:0]        req_pixel_color = '0;
   logic               req_pinned = 1'b0;
   raster_word_type    req_pin = '0;

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [12:0] rsp_x_start;
   logic signed [12:0] rsp_x_end;
   logic signed [12:0] rsp_row;
   logic [31:0]        rsp_color_out;
   logic               rsp_done_res;
   logic               rsp_last;

   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [SURF_BITS-1:0]    csr_data = '0;

   circle_point_generator_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_radius      (req_radius),
      .req_pixel_color (req_pixel_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_x_start     (rsp_x_start),
      .rsp_x_end       (rsp_x_end),
      .rsp_row         (rsp_row),
      .rsp_color_out   (rsp_color_out),
      .rsp_done_res    (rsp_done_res),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor: mirrors the walk state and the surface registers
   // ------------------------------------------------------------------
   bit                 cfg_fill = 1'b0;
   logic [11:0]        cfg_width = SURF_WIDTH_RESET;
   logic [11:0]        cfg_height = SURF_HEIGHT_RESET;
   logic [11:0]        walk_x = '0;
   logic signed [12:0] walk_y = -13'sd1;     // negative means walk finished
   logic signed [15:0] walk_d = '0;
   logic signed [11:0] held_cx = '0;
   logic signed [11:0] held_cy = '0;
   logic [31:0]        held_col = '0;

   raster_word_type pending_points[$];

   int failures = 0;
   int requests_taken = 0;
   int words_checked = 0;
   int done_words = 0;
   int burst_left = 0;
   bit idling_on = 1'b1;

   // run limit, far above the slowest legal run
   initial begin
      #3000000;
      $display("timeout at %0t, %0d points still pending", $time, pending_points.size());
      $display("Regression FAIL");
      $finish;
   end

   function automatic void queue_point(input int xs, input int xe, input int r,
                                       input bit done, input bit last);
      raster_word_type w;
      w.x_start = 13'(xs);
      w.x_end   = 13'(xe);
      w.row     = 13'(r);
      w.color   = held_col;
      w.done    = done;
      w.last    = last;
      pending_points.push_back(w);
   endfunction

   function automatic void advance_walk(input cmd_type cmd, input logic signed [11:0] cx,
                                        input logic signed [11:0] cy, input logic [10:0] rad,
                                        input logic [31:0] col);
      int x, y, d, err, right, left, lower, upper;
      // start word loads the circle and yields nothing
      if (cmd == CMD_START) begin
         held_cx  = cx;
         held_cy  = cy;
         held_col = col;
         walk_x   = '0;
         walk_y   = 13'(int'(rad));
         walk_d   = 16'(1 - 2 * int'(rad));
         return;
      end
      // finished walk, including a step straight after reset
      if (walk_y < 0) begin
         queue_point(0, 0, 0, 1'b1, 1'b1);
         return;
      end
      x = int'(walk_x);
      y = int'(walk_y);
      d = int'(walk_d);
      right = int'(held_cx) + x;
      left  = int'(held_cx) - x;
      lower = int'(held_cy) + y;
      upper = int'(held_cy) - y;
      // surface clamps; a low column goes to -1 while a low row goes to 0
      if (right > int'(cfg_width) - 1) right = int'(cfg_width) - 1;
      if (lower > int'(cfg_height) - 1) lower = int'(cfg_height) - 1;
      if (left < 0) left = -1;
      if (upper < 0) upper = 0;
      if (cfg_fill) begin
         queue_point(right, left, lower, 1'b0, 1'b0);
         queue_point(right, left, upper, 1'b0, 1'b1);
      end else begin
         queue_point(right, right, lower, 1'b0, 1'b0);
         queue_point(right, right, upper, 1'b0, 1'b0);
         queue_point(left, left, lower, 1'b0, 1'b0);
         queue_point(left, left, upper, 1'b0, 1'b1);
      end
      // midpoint error walk: step right, step down, or both
      err = 2 * (d + y) - 1;
      if (d < 0 && err <= 0) begin
         x = x + 1;
         d = d + 2 * x + 1;
      end else if (d > 0 && err > 0) begin
         y = y - 1;
         d = d - (2 * y + 1);
      end else begin
         x = x + 1;
         y = y - 1;
         d = d + 2 * (x - y);
      end
      walk_x = 12'(x);
      walk_y = 13'(y);
      walk_d = 16'(d);
   endfunction

   function automatic void compare_point(input string what, input raster_word_type want,
                                         input raster_word_type got);
      if (want === got) return;
      failures++;
      if (want.x_start !== got.x_start)
         $display("%0t %s x_start expected %0d actual %0d", $time, what,
                  want.x_start, got.x_start);
      if (want.x_end !== got.x_end)
         $display("%0t %s x_end expected %0d actual %0d", $time, what, want.x_end, got.x_end);
      if (want.row !== got.row)
         $display("%0t %s row expected %0d actual %0d", $time, what, want.row, got.row);
      if (want.color !== got.color)
         $display("%0t %s color_out expected %h actual %h", $time, what, want.color, got.color);
      if (want.done !== got.done)
         $display("%0t %s done_res expected %b actual %b", $time, what, want.done, got.done);
      if (want.last !== got.last)
         $display("%0t %s last expected %b actual %b", $time, what, want.last, got.last);
   endfunction

   // ------------------------------------------------------------------
   // monitor: checks results, then folds in register writes and requests
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      raster_word_type got;
      int first_idx;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_x_start, rsp_x_end, rsp_row, rsp_color_out, rsp_done_res, rsp_last};
            if (pending_points.size() == 0) begin
               failures++;
               $display("%0t unexpected word x_start %0d x_end %0d row %0d done %b",
                        $time, got.x_start, got.x_end, got.row, got.done);
            end else begin
               compare_point("result", pending_points.pop_front(), got);
               words_checked++;
               if (got.done) done_words++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FILL_MODE:   cfg_fill = csr_data[0];
               CSR_SURF_WIDTH:  cfg_width = csr_data;
               CSR_SURF_HEIGHT: cfg_height = csr_data;
               default: ;       // unmapped index changes nothing
            endcase
         end
         if (req_valid && req_ready) begin
            first_idx = pending_points.size();
            advance_walk(cmd_type'(req_command), req_center_x, req_center_y, req_radius,
                         req_pixel_color);
            requests_taken++;
            // hand-typed first result of a directed row
            if (req_pinned) begin
               if (pending_points.size() > first_idx)
                  compare_point("pinned", req_pin, pending_points[first_idx]);
               else begin
                  failures++;
                  $display("%0t pinned row predicts no word", $time);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver: runs of ready broken by short stalls, stalls off when quiet
   // ------------------------------------------------------------------
   int rsp_run_left = 0;
   int rsp_hold_left = 0;

   always @(posedge clock) begin : rsp_pattern
      if (rsp_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_run_left > 0) begin
            rsp_run_left = rsp_run_left - 1;
         end else begin
            rsp_run_left  = $urandom_range(0, 9);
            rsp_hold_left = idling_on ? $urandom_range(1, 5) : 0;
         end
      end
   end

   // ------------------------------------------------------------------
   // sender: bursts of words separated by random gaps
   // ------------------------------------------------------------------
   task automatic send_request(input stim_row_type row);
      int gap;
      if (burst_left == 0) begin
         gap = idling_on ? $urandom_range(0, 4) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 8);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_command     <= row.command;
      req_center_x    <= row.center_x;
      req_center_y    <= row.center_y;
      req_radius      <= row.radius;
      req_pixel_color <= row.pixel_color;
      req_pinned      <= row.pinned;
      req_pin         <= row.pin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // register write; valid stays up so back-to-back writes need no drop
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] index,
                            input logic [SURF_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // let every expected word out, then idle to let a trailing start word through
   task automatic drain_points();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_points.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_surface(input bit fill, input logic [11:0] w, input logic [11:0] h,
                              input bit poke_unmapped);
      drain_points();
      // upper data bits of the mode write are don't care
      write_reg(CSR_FILL_MODE, {11'($urandom), fill});
      write_reg(CSR_SURF_WIDTH, w);
      write_reg(CSR_SURF_HEIGHT, h);
      if (poke_unmapped) write_reg(CSR_UNMAPPED, 12'($urandom));
      csr_valid <= 1'b0;
   endtask

   // centers cluster around the surface borders so the clamps get hit
   function automatic logic signed [11:0] pick_center(input int limit);
      int v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = $urandom_range(0, 40) - 20;
         2: v = limit + $urandom_range(0, 40) - 20;
         default: v = $urandom_range(0, limit);
      endcase
      return 12'(v);
   endfunction

   function automatic stim_row_type noise_row();
      stim_row_type row;
      row             = '0;
      row.command     = cmd_type'($urandom_range(0, 1));
      row.center_x    = 12'($urandom);
      row.center_y    = 12'($urandom);
      row.radius      = 11'($urandom);
      row.pixel_color = $urandom;
      return row;
   endfunction

   // mostly whole circles (start then a run of steps), some loose noise words
   task automatic run_random(input int budget);
      int left, steps, pick;
      stim_row_type row;
      left = budget;
      while (left > 0) begin
         if ($urandom_range(0, 9) < 7) begin
            row             = noise_row();
            row.command     = CMD_START;
            row.center_x    = pick_center(int'(cfg_width));
            row.center_y    = pick_center(int'(cfg_height));
            pick            = $urandom_range(0, 19);
            if (pick < 16) row.radius = 11'($urandom_range(0, 12));
            else if (pick < 19) row.radius = 11'($urandom_range(13, 60));
            send_request(row);
            left--;
            // small circles run past their end so done words show up
            if (row.radius <= 60) steps = int'(row.radius) + int'(row.radius) / 2 + 3;
            else steps = $urandom_range(1, 8);
            if (steps > 30) steps = 30;
            if (steps > left) steps = left;
            repeat (steps) begin
               row         = noise_row();
               row.command = CMD_STEP;
               send_request(row);
               left--;
            end
         end else begin
            send_request(noise_row());
            left--;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // directed table, reset surface 640 x 480 in outline mode
   // ------------------------------------------------------------------
   stim_row_type directed_rows [N_DIRECTED] = '{
      // step straight after reset: done word with zero color
      '{CMD_STEP,  12'h7FF, 12'h800, 11'h7FF, 32'hFFFF_FFFF, 1'b1,
        '{13'sd0, 13'sd0, 13'sd0, 32'h0000_0000, 1'b1, 1'b1}},
      // zero radius: one step of points at the origin, then done
      '{CMD_START, 12'h000, 12'h000, 11'd0, 32'hFFFF_FFFF, 1'b0, NO_PIN},
      '{CMD_STEP,  12'h000, 12'h000, 11'd0, 32'h0000_0000, 1'b1,
        '{13'sd0, 13'sd0, 13'sd0, 32'hFFFF_FFFF, 1'b0, 1'b0}},
      '{CMD_STEP,  12'h000, 12'h000, 11'd0, 32'h0000_0000, 1'b1,
        '{13'sd0, 13'sd0, 13'sd0, 32'hFFFF_FFFF, 1'b1, 1'b1}},
      // most negative center, largest radius
      '{CMD_START, 12'h800, 12'h800, 11'h7FF, 32'h0000_0000, 1'b0, NO_PIN},
      '{CMD_STEP,  12'h123, 12'hEDC, 11'h2AA, 32'h5555_5555, 1'b1,
        '{-13'sd2048, -13'sd2048, -13'sd1, 32'h0000_0000, 1'b0, 1'b0}},
      '{CMD_STEP,  12'hEDC, 12'h123, 11'h555, 32'hAAAA_AAAA, 1'b0, NO_PIN},
      // most positive center, clamped to the right and bottom edges
      '{CMD_START, 12'h7FF, 12'h7FF, 11'h7FF, 32'hA5A5_5A5A, 1'b0, NO_PIN},
      '{CMD_STEP,  12'h000, 12'h000, 11'd0, 32'h0000_0000, 1'b1,
        '{13'sd639, 13'sd639, 13'sd479, 32'hA5A5_5A5A, 1'b0, 1'b0}},
      '{CMD_STEP,  12'h000, 12'h000, 11'd0, 32'h0000_0000, 1'b0, NO_PIN},
      // radius one walked to its end
      '{CMD_START, 12'd320, 12'd240, 11'd1, 32'h0000_00FF, 1'b0, NO_PIN},
      '{CMD_STEP,  12'h000, 12'h000, 11'd0, 32'h0000_0000, 1'b0, NO_PIN},
      '{CMD_STEP,  12'h000, 12'h000, 11'd0, 32'h0000_0000, 1'b0, NO_PIN},
      '{CMD_STEP,  12'h000, 12'h000, 11'd0, 32'h0000_0000, 1'b0, NO_PIN},
      '{CMD_STEP,  12'h000, 12'h000, 11'd0, 32'h0000_0000, 1'b1,
        '{13'sd0, 13'sd0, 13'sd0, 32'h0000_00FF, 1'b1, 1'b1}},
      // near the top left corner: low row clamp
      '{CMD_START, 12'd5, 12'd3, 11'd6, 32'h8000_0001, 1'b0, NO_PIN},
      '{CMD_STEP,  12'h000, 12'h000, 11'd0, 32'h0000_0000, 1'b0, NO_PIN},
      '{CMD_STEP,  12'h000, 12'h000, 11'd0, 32'h0000_0000, 1'b0, NO_PIN},
      '{CMD_STEP,  12'h000, 12'h000, 11'd0, 32'h0000_0000, 1'b0, NO_PIN},
      '{CMD_STEP,  12'h000, 12'h000, 11'd0, 32'h0000_0000, 1'b0, NO_PIN},
      '{CMD_STEP,  12'h000, 12'h000, 11'd0, 32'h0000_0000, 1'b0, NO_PIN},
      '{CMD_STEP,  12'h000, 12'h000, 11'd0, 32'h0000_0000, 1'b0, NO_PIN},
      // centered on the bottom right pixel
      '{CMD_START, 12'd639, 12'd479, 11'd3, 32'h7FFF_FFFF, 1'b0, NO_PIN},
      '{CMD_STEP,  12'h000, 12'h000, 11'd0, 32'h0000_0000, 1'b0, NO_PIN},
      '{CMD_STEP,  12'h000, 12'h000, 11'd0, 32'h0000_0000, 1'b0, NO_PIN}
   };

   // surface settings per random phase; the sixth one is drawn at random
   bit          phase_fill   [N_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
   logic [11:0] phase_width  [N_PHASES] = '{12'd640, 12'd2048, 12'd1, 12'd0, 12'd4095,
                                            12'd0, 12'd100};
   logic [11:0] phase_height [N_PHASES] = '{12'd480, 12'd2048, 12'd1, 12'd0, 12'd4095,
                                            12'd0, 12'd50};

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin : main
      logic [11:0] w, h;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table at the reset surface
      for (int i = 0; i < N_DIRECTED; i++) send_request(directed_rows[i]);

      // random phases, each on its own surface setting
      for (int p = 0; p < N_PHASES; p++) begin
         w = phase_width[p];
         h = phase_height[p];
         if (p == 5) begin
            w = 12'($urandom_range(1, 2048));
            h = 12'($urandom_range(1, 2048));
         end
         set_surface(phase_fill[p], w, h, p == 5);
         // every third phase runs flat out on both sides
         idling_on = (p % 3) != 2;
         run_random(PHASE_ITEMS);
      end

      drain_points();
      $display("took %0d request words and checked %0d result words, %0d of them done words",
               requests_taken, words_checked, done_words);
      $display("surface settings visited: reset plus %0d phases, outline and fill", N_PHASES);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", failures);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
